// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int DEPTH     = 64;
	localparam int KEY_WIDTH = 24;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef struct packed {
		logic        op;
		logic [23:0] key;
		logic [7:0]  tag;
		logic [19:0] population;
		logic [1:0]  damage_level;
	} req_t;

	typedef struct packed {
		logic        out_valid;
		logic [23:0] out_key;
		logic [7:0]  out_tag;
		logic [19:0] out_population;
		logic [1:0]  out_damage;
		logic        overflow;
		logic [6:0]  entry_count;
		logic        is_empty;
	} rsp_t;

	// one stored entry
	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic [7:0]           tag;
		logic [19:0]          population;
		logic [1:0]           damage;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t new_ent;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  logic              left_ge,
	input  spq_pkg::entry_t   left_ent,
	input  spq_pkg::entry_t   right_ent,
	output spq_pkg::entry_t   ent,
	output logic              ge
);
	import spq_pkg::*;

	entry_t ent_q;

	// held entry ranks ahead of (or ties with) the new one
	assign ge  = occ && (ent_q.key >= ctl.new_ent.key);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && !ge) begin
			// first non-ge cell takes the new entry, cells behind it shift back
			ent_q <= left_ge ? ctl.new_ent : left_ent;
		end else if (ctl.deq) begin
			ent_q <= right_ent;
		end
	end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// channel  | valid     | ready     | payload | one transaction
// ---------+-----------+-----------+---------+-------------------------------------
// request  | req_valid | req_ready | req     | one enqueue or dequeue
// response | rsp_valid | rsp_ready | rsp     | the result of that request
//
// one request per cycle unless an unread response stalls it; its result appears in the response register the next cycle
// the cell chain compares and shifts all entries in the same cycle as the request
// arst_n clears the entry count and the response valid flag; entry contents and the
// response payload are not reset
// a stalled response blocks new requests only while it is still unread
module sorted_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             do_enq;
	logic             do_deq;
	logic [CNT_W-1:0] count_next;
	cell_ctl_t        ctl;
	entry_t           new_ent;

	entry_t           ents [DEPTH];
	logic [DEPTH-1:0] ges;
	logic [DEPTH-1:0] occ;

	// response register frees up as soon as it is read
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// a full enqueue and an empty dequeue leave the chain untouched
	assign do_enq = accept && (req.op == OP_ENQ) && !full;
	assign do_deq = accept && (req.op == OP_DEQ) && !empty;

	assign new_ent.key        = req.key[KEY_WIDTH-1:0];
	assign new_ent.tag        = req.tag;
	assign new_ent.population = req.population;
	assign new_ent.damage     = req.damage_level;

	assign ctl.enq     = do_enq;
	assign ctl.deq     = do_deq;
	assign ctl.new_ent = new_ent;

	always_comb begin
		count_next = count_q;
		if (do_enq) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_deq) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// the chain: cell 0 is the front (highest key)
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_ge;

		// a cell is occupied when it sits below the entry count
		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_ent = new_ent;
			assign left_ge  = 1'b1;
		end else begin : g_mid
			assign left_ent = ents[i-1];
			assign left_ge  = ges[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			// slot past the tail is never read
			assign right_ent = ents[i];
		end else begin : g_inner
			assign right_ent = ents[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ[i]),
			.left_ge   (left_ge),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.ent       (ents[i]),
			.ge        (ges[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, captured with the request transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.out_valid      <= do_deq;
			rsp_q.out_key        <= do_deq ? 24'(ents[0].key) : '0;
			rsp_q.out_tag        <= do_deq ? ents[0].tag : '0;
			rsp_q.out_population <= do_deq ? ents[0].population : '0;
			rsp_q.out_damage     <= do_deq ? ents[0].damage : '0;
			rsp_q.overflow       <= (req.op == OP_ENQ) && full;
			rsp_q.entry_count    <= 7'(count_next);
			rsp_q.is_empty       <= (count_next == '0);
		end
	end

endmodule
